// File: rtl/psbfe_pkg.sv
// Shared types and constants of the pixel store blend and fill engine.
`default_nettype none

package psbfe_pkg;

	localparam int CFG_W   = 9;
	localparam int COORD_W = 8;
	localparam int COLOR_W = 32;
	localparam int OP_W    = 3;
	// line_width * y + x and line_width * line_count both fit in 18 bits
	localparam int IDX_W   = 18;

	localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
	localparam logic [OP_W-1:0] OP_READ  = 3'd1;
	localparam logic [OP_W-1:0] OP_BLEND = 3'd2;
	localparam logic [OP_W-1:0] OP_FILL  = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

	localparam logic [1:0] REG_LINE_WIDTH = 2'd0;
	localparam logic [1:0] REG_LINE_COUNT = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_ISSUE,
		ST_READ_WAIT,
		ST_BLEND,
		ST_FILL,
		ST_CLEAR,
		ST_RESP
	} state_t;

endpackage

`default_nettype wire

// File: rtl/pixel_store_blend_fill_engine.sv
// Top level of the pixel store blend and fill engine.
`default_nettype none

// RGBA8 pixel store of MAX_WIDTH*MAX_HEIGHT words in one single-port synchronous
// memory, addressed by line_width*y + x. Each transaction is handled by a sequencer
// that owns the memory port: a write passes through states IDLE, CALC, ISSUE and
// RESP, a read or blend adds READ_WAIT or BLEND after ISSUE (a blend writes the mixed
// pixel back in the cycle in which the read data arrives). A rectangle fill writes
// each pixel of the rectangle in FILL, a clear each pixel of line_width*line_count
// in CLEAR. The memory port allows one access a cycle.
// Results sit in an output register, so a new item is taken while one waits there.
// Stored pixels are undefined until written.
module pixel_store_blend_fill_engine #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [8:0]  cfg_data,
	// request stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,  // pos_x[7:0], pos_y[15:8], end_x[23:16], end_y[31:24],
	                                   // color[63:32]
	input  wire logic [2:0]  s_tuser,  // op[2:0]
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // read_color[31:0]
	output logic [0:0]       m_tuser   // status[0]
);

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam int IW = psbfe_pkg::IDX_W;
	localparam int CW = psbfe_pkg::COORD_W;

	psbfe_pkg::state_t state_q, state_d;

	logic [psbfe_pkg::CFG_W-1:0]   line_width_q, line_count_q;
	logic [psbfe_pkg::CFG_W-1:0]   eff_w, eff_h;

	// request captured at accept
	logic [psbfe_pkg::OP_W-1:0]    op_s1;
	logic [CW-1:0]                 pos_x_s1, pos_y_s1, end_x_s1, end_y_s1;
	logic [psbfe_pkg::COLOR_W-1:0] color_s1;

	// linear indices and pixel count
	logic [IW-1:0] idx_s2, end_idx_s2, total_s2;
	logic          idx_ok, end_ok, rect_ok;

	// fill and clear walk
	logic [CW-1:0] x_q, y_q;
	logic [IW-1:0] addr_q, row_q;
	logic          fill_last, clear_last;

	logic [psbfe_pkg::COLOR_W-1:0] res_color_q;
	logic                          res_status_q;
	logic [psbfe_pkg::COLOR_W-1:0] out_color_q;
	logic                          out_status_q, out_valid_q;

	logic                          mem_we;
	logic [IW-1:0]                 mem_idx;
	logic [psbfe_pkg::COLOR_W-1:0] mem_wdata, mem_rdata_q;
	logic                          out_load;

	logic [psbfe_pkg::COLOR_W-1:0] mem [DEPTH];

	function automatic logic [31:0] blend_px(input logic [31:0] cur, input logic [31:0] add);
		logic [7:0]  a;
		logic [15:0] t;
		logic [15:0] q;
		logic [31:0] res;
		a   = add[31:24];
		res = '0;
		for (int ch = 0; ch < 4; ch++) begin
			t = 16'(cur[ch*8 +: 8]) * 16'(8'd255 - a) + 16'(add[ch*8 +: 8]) * 16'(a) + 16'd127;
			// exact t / 255 over the whole range that t reaches here
			q = (t + 16'd1 + (t >> 8)) >> 8;
			res[ch*8 +: 8] = q[7:0];
		end
		return res;
	endfunction

	assign cfg_ready = 1'b1;

	// clamp the registers to the store dimensions
	assign eff_w = (int'(line_width_q) > MAX_WIDTH)  ? psbfe_pkg::CFG_W'(MAX_WIDTH)  : line_width_q;
	assign eff_h = (int'(line_count_q) > MAX_HEIGHT) ? psbfe_pkg::CFG_W'(MAX_HEIGHT) : line_count_q;

	assign idx_ok     = idx_s2 < total_s2;
	assign end_ok     = end_idx_s2 < total_s2;
	assign rect_ok    = (pos_x_s1 <= end_x_s1) && (pos_y_s1 <= end_y_s1);
	assign fill_last  = (x_q == end_x_s1) && (y_q == end_y_s1);
	assign clear_last = addr_q == (total_s2 - IW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= '0;
			line_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				psbfe_pkg::REG_LINE_WIDTH: line_width_q <= cfg_data;
				psbfe_pkg::REG_LINE_COUNT: line_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psbfe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			psbfe_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = psbfe_pkg::ST_CALC;
			end
			psbfe_pkg::ST_CALC: state_d = psbfe_pkg::ST_ISSUE;
			psbfe_pkg::ST_ISSUE: begin
				unique case (op_s1)
					psbfe_pkg::OP_READ:
						state_d = idx_ok ? psbfe_pkg::ST_READ_WAIT : psbfe_pkg::ST_RESP;
					psbfe_pkg::OP_BLEND:
						state_d = idx_ok ? psbfe_pkg::ST_BLEND : psbfe_pkg::ST_RESP;
					psbfe_pkg::OP_FILL:
						state_d = (idx_ok && end_ok && rect_ok) ? psbfe_pkg::ST_FILL
						                                        : psbfe_pkg::ST_RESP;
					psbfe_pkg::OP_CLEAR:
						state_d = (total_s2 != '0) ? psbfe_pkg::ST_CLEAR : psbfe_pkg::ST_RESP;
					default: state_d = psbfe_pkg::ST_RESP;
				endcase
			end
			psbfe_pkg::ST_READ_WAIT: state_d = psbfe_pkg::ST_RESP;
			psbfe_pkg::ST_BLEND:     state_d = psbfe_pkg::ST_RESP;
			psbfe_pkg::ST_FILL: begin
				if (fill_last) state_d = psbfe_pkg::ST_RESP;
			end
			psbfe_pkg::ST_CLEAR: begin
				if (clear_last) state_d = psbfe_pkg::ST_RESP;
			end
			psbfe_pkg::ST_RESP: begin
				if (!out_valid_q || m_tready) state_d = psbfe_pkg::ST_IDLE;
			end
			default: state_d = psbfe_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		mem_we    = 1'b0;
		mem_idx   = idx_s2;
		mem_wdata = color_s1;
		out_load  = 1'b0;
		unique case (state_q) inside
			psbfe_pkg::ST_IDLE: s_tready = 1'b1;
			psbfe_pkg::ST_ISSUE: begin
				mem_we = (op_s1 == psbfe_pkg::OP_WRITE) && idx_ok;
			end
			psbfe_pkg::ST_BLEND: begin
				mem_we    = 1'b1;
				mem_wdata = blend_px(mem_rdata_q, color_s1);
			end
			psbfe_pkg::ST_FILL, psbfe_pkg::ST_CLEAR: begin
				mem_we  = 1'b1;
				mem_idx = addr_q;
			end
			psbfe_pkg::ST_RESP: out_load = !out_valid_q || m_tready;
			default: ;
		endcase
	end

	// pixel store: one port, registered read data
	always_ff @(posedge clk) begin
		if (mem_we) mem[ADDR_W'(mem_idx)] <= mem_wdata;
		mem_rdata_q <= mem[ADDR_W'(mem_idx)];
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1    <= s_tuser;
			pos_x_s1 <= s_tdata[7:0];
			pos_y_s1 <= s_tdata[15:8];
			end_x_s1 <= s_tdata[23:16];
			end_y_s1 <= s_tdata[31:24];
			color_s1 <= s_tdata[63:32];
		end
		if (state_q == psbfe_pkg::ST_CALC) begin
			idx_s2     <= IW'(eff_w) * IW'(pos_y_s1) + IW'(pos_x_s1);
			end_idx_s2 <= IW'(eff_w) * IW'(end_y_s1) + IW'(end_x_s1);
			total_s2   <= IW'(eff_w) * IW'(eff_h);
		end
	end

	// walk the rectangle row by row, or the whole buffer for a clear
	always_ff @(posedge clk) begin
		unique case (state_q)
			psbfe_pkg::ST_ISSUE: begin
				x_q    <= pos_x_s1;
				y_q    <= pos_y_s1;
				row_q  <= idx_s2;
				addr_q <= (op_s1 == psbfe_pkg::OP_CLEAR) ? '0 : idx_s2;
			end
			psbfe_pkg::ST_FILL: begin
				if (x_q == end_x_s1) begin
					x_q    <= pos_x_s1;
					y_q    <= y_q + CW'(1);
					row_q  <= row_q + IW'(eff_w);
					addr_q <= row_q + IW'(eff_w);
				end else begin
					x_q    <= x_q + CW'(1);
					addr_q <= addr_q + IW'(1);
				end
			end
			psbfe_pkg::ST_CLEAR: addr_q <= addr_q + IW'(1);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == psbfe_pkg::ST_ISSUE) begin
			res_color_q <= '0;
			unique case (op_s1) inside
				psbfe_pkg::OP_WRITE, psbfe_pkg::OP_READ, psbfe_pkg::OP_BLEND:
					res_status_q <= !idx_ok;
				psbfe_pkg::OP_FILL:
					res_status_q <= !(idx_ok && end_ok);
				default:
					res_status_q <= 1'b0;
			endcase
		end else if (state_q == psbfe_pkg::ST_READ_WAIT) begin
			res_color_q <= mem_rdata_q;
		end
	end

	// output register: hold the result until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_color_q  <= res_color_q;
			out_status_q <= res_status_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_color_q;
	assign m_tuser  = out_status_q;

endmodule

`default_nettype wire
